### design/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg: shared definitions for the row softmax block
// Widths, exponential constants and the divider status type.
// ----------------------------------------------------------------------------
`default_nettype none

package rsm_pkg;

  localparam int MAX_COLS   = 64;
  localparam int IDX_W      = $clog2(MAX_COLS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int E_W        = 16;
  localparam int SUM_W      = 22;
  // The row maximum always contributes 63635, so the reciprocal stays below 2^17.
  localparam int RECIP_W    = 17;
  localparam int DIVIDEND_W = 33;

  localparam logic [24:0]        EXP_SCALE      = 25'd12102203;
  localparam logic signed [33:0] EXP_BIAS       = 34'sd1064866805;
  localparam logic signed [16:0] EXP_FLOOR      = -17'sd22348;
  localparam logic [8:0]         EXP_BASE_SHIFT = 9'd134;

  typedef struct packed {
    logic               done;
    logic [RECIP_W-1:0] quot;
  } rsm_div_stat_t;

endpackage

`default_nettype wire

### design/rsm_recip.sv
// ----------------------------------------------------------------------------
// rsm_recip: iterative reciprocal of the exponential sum
// Restoring long division of 2^32 by the sum, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_recip import rsm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] divisor,
  output rsm_div_stat_t         stat
);

  logic                  busy_r;
  logic [5:0]            step_r;
  logic [SUM_W-1:0]      div_r;
  logic [SUM_W:0]        rem_r;
  logic [DIVIDEND_W-1:0] quot_r;
  logic                  done_r;

  logic [SUM_W:0] trial;
  logic           qbit;

  // The dividend is a single one followed by 32 zeros.
  assign trial = {rem_r[SUM_W-1:0], (step_r == 6'd0)};
  assign qbit  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 6'd1;
        if (step_r == 6'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= qbit ? (trial - {1'b0, div_r}) : trial;
      quot_r <= {quot_r[DIVIDEND_W-2:0], qbit};
    end
  end

  assign stat.done = done_r;
  assign stat.quot = (div_r == '0) ? '0 : quot_r[RECIP_W-1:0];

endmodule

`default_nettype wire

### design/row_softmax_fast_exp.sv
// Flow: after the closing word the row (1 to 64 elements) runs the exponential sum
// (read, multiply, exponent per element), the reciprocal, then the results (read,
// multiply, exponent, normalise, output per element, plus any output stall).
// Throughput: one shared multiplier and the bit-serial divider set the rate; no input
// is taken from the closing word until the last result is in the output register.
// Reset (synchronous, rst_n low) empties the row and clears the output valid.
// ----------------------------------------------------------------------------
// row_softmax_fast_exp: row softmax with a bit-trick exponential
// Buffers a row of Q7.8 samples and emits normalised Q0.16 probabilities.
// ----------------------------------------------------------------------------
`default_nettype none

module row_softmax_fast_exp import rsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample
  input  wire logic        in_tlast,   // row_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] prob
  output logic             out_tlast   // prob_last
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_RD  = 4'd1;
  localparam logic [3:0] S_A_MUL = 4'd2;
  localparam logic [3:0] S_A_EXP = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_B_RD  = 4'd5;
  localparam logic [3:0] S_B_MUL = 4'd6;
  localparam logic [3:0] S_B_EXP = 4'd7;
  localparam logic [3:0] S_B_NRM = 4'd8;
  localparam logic [3:0] S_B_OUT = 4'd9;

  logic [3:0]                 state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic [IDX_W-1:0]           idx_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic [SUM_W-1:0]           sum_r;
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic signed [42:0]         prod_r;
  logic                       under_r;
  logic [E_W-1:0]             e_r;
  logic [RECIP_W-1:0]         recip_r;
  logic [15:0]                out_data_r;
  logic                       out_last_r;
  logic                       out_valid_r;

  logic signed [SAMPLE_W-1:0] row_mem [MAX_COLS];

  logic                 in_acc, closing, last_idx, out_free, div_start;
  logic signed [16:0]   diff;
  logic signed [24:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic [E_W-1:0]       e_val;
  logic [SUM_W-1:0]     sum_add;
  rsm_div_stat_t        div_stat;

  function automatic logic [E_W-1:0] fast_exp(input logic signed [40:0] p);
    logic signed [33:0] y;
    logic [7:0]         ex;
    logic [8:0]         sh;
    logic [23:0]        mant;
    logic [23:0]        shifted;
    y    = {p[40], p[40:8]} + EXP_BIAS;
    ex   = y[30:23];
    mant = {1'b1, y[22:0]};
    sh   = ({1'b0, ex} >= EXP_BASE_SHIFT) ? 9'd0 : (EXP_BASE_SHIFT - {1'b0, ex});
    shifted = mant >> sh[4:0];
    return (sh >= 9'd32) ? '0 : shifted[E_W-1:0];
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign closing   = in_tlast || (cnt_r == CNT_W'(MAX_COLS - 1));
  assign last_idx  = ({1'b0, idx_r} == (cnt_r - CNT_W'(1)));
  assign out_free  = !out_valid_r || out_tready;
  assign diff      = 17'(rdata_r) - 17'(max_r);
  assign e_val     = under_r ? '0 : fast_exp(prod_r[40:0]);
  assign sum_add   = sum_r + SUM_W'(e_val);
  assign div_start = (state_r == S_A_EXP) && last_idx;

  // The one multiplier serves the exponent scaling and the normalisation.
  always_comb begin
    if (state_r == S_A_MUL || state_r == S_B_MUL) begin
      mul_a = $signed({1'b0, EXP_SCALE[23:0]});
      mul_b = 18'(diff);
    end else begin
      mul_a = $signed(25'(e_r));
      mul_b = $signed({1'b0, recip_r});
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && closing) state_nxt = S_A_RD;
      S_A_RD:  state_nxt = S_A_MUL;
      S_A_MUL: state_nxt = S_A_EXP;
      S_A_EXP: state_nxt = last_idx ? S_DIV : S_A_RD;
      S_DIV:   if (div_stat.done) state_nxt = S_B_RD;
      S_B_RD:  state_nxt = S_B_MUL;
      S_B_MUL: state_nxt = S_B_EXP;
      S_B_EXP: state_nxt = S_B_NRM;
      S_B_NRM: state_nxt = S_B_OUT;
      S_B_OUT: if (out_free) state_nxt = last_idx ? S_IDLE : S_B_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      max_r       <= 16'sh8000;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_B_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cnt_r <= cnt_r + CNT_W'(1);
            if ($signed(in_tdata) > max_r) max_r <= $signed(in_tdata);
            idx_r <= '0;
          end
        end
        S_A_EXP: begin
          sum_r <= sum_add;
          idx_r <= last_idx ? '0 : idx_r + IDX_W'(1);
        end
        S_B_OUT: begin
          if (out_free) begin
            if (last_idx) begin
              cnt_r <= '0;
              max_r <= 16'sh8000;
              sum_r <= '0;
              idx_r <= '0;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) row_mem[cnt_r[IDX_W-1:0]] <= $signed(in_tdata);
    rdata_r <= row_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_A_MUL || state_r == S_B_MUL) begin
      prod_r  <= mul_a * mul_b;
      under_r <= (diff < EXP_FLOOR);
    end else if (state_r == S_B_NRM) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == S_B_EXP) e_r <= e_val;
    if (state_r == S_DIV && div_stat.done) recip_r <= div_stat.quot;
    if (state_r == S_B_OUT && out_free) begin
      out_data_r <= (|prod_r[42:32]) ? 16'hFFFF : prod_r[31:16];
      out_last_r <= last_idx;
    end
  end

  rsm_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (sum_add),
    .stat    (div_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### design/rsm_check.sv
// ----------------------------------------------------------------------------
// rsm_check: port-level checks for the row softmax block
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsm_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [15:0] in_tdata,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // A closing word starts the row computation, so no input is taken next.
  a_busy_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken straight after a closing word");

  // The last result of a row is never followed at once by another result.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("result word straight after the end of a row");

endmodule

bind row_softmax_fast_exp rsm_check u_rsm_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for row_softmax_fast_exp
// Streams rows of Q7.8 samples through the block, predicts the normalised
// probabilities of every closed row and compares each output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rsm_pkg::*;

  typedef struct packed {
    logic [15:0] sample;
    logic        row_end;
  } sample_word_t;

  typedef struct packed {
    logic [15:0] prob;
    logic        last;
  } prob_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  row_softmax_fast_exp dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_word_t pending_words[$];
  prob_word_t   expected_probs[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           hold_sender = 0;

  // Predictor state
  logic signed [15:0] row_buf[MAX_COLS];
  int                 row_len = 0;
  logic signed [15:0] row_max = -16'sd32768;

  function automatic logic [31:0] exp_approx(input int d_raw);
    longint y;
    longint unsigned u;
    int unsigned ex, mant, sh;
    if (d_raw < -22348) return 0;
    y = longint'(d_raw) * 64'sd12102203 + 64'sd1064866805 * 256;
    if (y < 0) return 0;
    u = longint'(y) >>> 8;
    ex = 32'(u >> 23);
    mant = 32'(u & 64'h7FFFFF);
    sh = (ex >= 134) ? 0 : 134 - ex;
    if (sh >= 32) return 0;
    return 32'(((64'd1 << 23) + mant) >> sh);
  endfunction

  task automatic predict_word(input sample_word_t w);
    logic [31:0] evals[MAX_COLS];
    longint unsigned total, recip, p;
    if (row_len >= MAX_COLS) row_len = 0;
    row_buf[row_len] = w.sample;
    row_len++;
    if ($signed(w.sample) > row_max) row_max = w.sample;
    if (!w.row_end && row_len < MAX_COLS) return;
    total = 0;
    for (int i = 0; i < row_len; i++) begin
      evals[i] = exp_approx(int'(row_buf[i]) - int'(row_max));
      total = (total + evals[i]) & 64'h3FFFFF;
    end
    recip = (total == 0) ? 0 : ((64'd1 << 32) / total);
    for (int i = 0; i < row_len; i++) begin
      p = (evals[i] * recip) >> 16;
      if (p > 65535) p = 65535;
      expected_probs.push_back('{prob: p[15:0], last: (i + 1 == row_len)});
    end
    row_len = 0;
    row_max = -16'sd32768;
  endtask

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_word(pending_words.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold the current word
      end else if (hold_sender || pending_words.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_words[0].sample;
        in_tlast <= pending_words[0].row_end;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor with its own stall pattern: phases of free flow and of random stalls.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_probs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word prob=%0d last=%0b", out_tdata, out_tlast);
        end else begin
          prob_word_t ex;
          ex = expected_probs.pop_front();
          if (ex.prob !== out_tdata || ex.last !== out_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected prob=%0d last=%0b, got prob=%0d last=%0b",
                       ex.prob, ex.last, out_tdata, out_tlast);
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 400;
      if (stall_phase < 150) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(4, 0) != 0);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: fails the run once idle_cycles, the run of cycles with no transfer on either port, passes its limit.
  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5, 0))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(16'h00FF, 0));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    logic [15:0] base;
    bit drained;
    drained = 0;
    // Directed: single element rows at the extremes and at zero.
    pending_words.push_back('{16'h8000, 1'b1});
    pending_words.push_back('{16'h7FFF, 1'b1});
    pending_words.push_back('{16'h0000, 1'b1});
    // Both extremes in one row: the minimum falls below the exponential floor.
    pending_words.push_back('{16'h8000, 1'b0});
    pending_words.push_back('{16'h7FFF, 1'b0});
    pending_words.push_back('{16'hFFFF, 1'b1});
    // Equal elements share the probability; small differences near the floor.
    pending_words.push_back('{16'h0100, 1'b0});
    pending_words.push_back('{16'h0100, 1'b0});
    pending_words.push_back('{16'h0100, 1'b0});
    pending_words.push_back('{16'h0100, 1'b1});
    pending_words.push_back('{16'h0000, 1'b0});
    pending_words.push_back('{16'hA8B4, 1'b0});
    pending_words.push_back('{16'hA8B3, 1'b0});
    pending_words.push_back('{16'hFF00, 1'b1});
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Random rows: mostly short, a few that run past the row limit without row_end.
    n = 0;
    while (n < 116) begin
      int len;
      case ($urandom_range(7, 0))
        0: len = 64;
        1: len = $urandom_range(70, 65);
        default: len = $urandom_range(10, 1);
      endcase
      if (len > 116 - n) len = 116 - n;
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        logic [15:0] s;
        if ($urandom_range(1, 0)) s = base + 16'($urandom_range(4095, 0)) - 16'd2048;
        else s = rand_sample();
        pending_words.push_back('{s, (i == len - 1) && len <= 64});
      end
      n += len;
      if (!drained && n > 60) begin
        // Let everything drain once before carrying on.
        wait (pending_words.size() == 0 && !in_tvalid);
        hold_sender = 1;
        wait (expected_probs.size() == 0);
        hold_sender = 0;
        drained = 1;
      end
    end
    // Close any row left open by the overlong ones.
    pending_words.push_back('{16'h0000, 1'b1});

    wait (pending_words.size() == 0 && !in_tvalid);
    wait (expected_probs.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_probs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### row_softmax_fast_exp.f
design/rsm_pkg.sv
design/rsm_recip.sv
design/row_softmax_fast_exp.sv
design/rsm_check.sv
sim/testbench.sv
